// ----- sv/abt_pkg.sv -----
// ============================================================================
// abt_pkg
// Shared types and constants for the American put binomial lattice pricer.
// ============================================================================
package abt_pkg;

    localparam int PRICE_W = 63;
    localparam int UP_W    = 34;
    localparam int FACT_W  = 33;
    localparam int NIN_W   = 11;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 64;

    typedef logic [PRICE_W-1:0] price_t;

    localparam price_t SAT_MAX = {PRICE_W{1'b1}};

    typedef enum logic [CIDX_W-1:0] {
        REG_UP     = 3'd0,
        REG_DOWN   = 3'd1,
        REG_WUP    = 3'd2,
        REG_WDN    = 3'd3,
        REG_STRIKE = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [UP_W-1:0]   up_factor;
        logic [FACT_W-1:0] down_factor;
        logic [FACT_W-1:0] weight_up;
        logic [FACT_W-1:0] weight_down;
        price_t            strike_price;
    } cfg_t;

    typedef struct packed {
        logic   idle;
        logic   done;
        price_t price;
        logic   sat;
    } status_t;

endpackage

// ----- sv/abt_mul.sv -----
// ============================================================================
// abt_mul
// Q31.32 multiplier with saturation; products and result are registered.
// ============================================================================
module abt_mul
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  abt_pkg::price_t         a,
    input  logic [abt_pkg::UP_W-1:0] b,
    output logic                    done,
    output abt_pkg::price_t         result,
    output logic                    sat
);

    logic            stage1_reg;
    logic            done_reg;
    logic [65:0]     pp_lo_reg;
    logic [64:0]     pp_hi_reg;
    logic [65:0]     pp_lo_next;
    logic [64:0]     pp_hi_next;
    logic [96:0]     full;
    abt_pkg::price_t result_reg;
    abt_pkg::price_t result_next;
    logic            sat_reg;
    logic            sat_next;

    assign pp_lo_next  = {34'b0, a[31:0]} * {32'b0, b};
    assign pp_hi_next  = {34'b0, a[62:32]} * {31'b0, b};
    assign full        = {pp_hi_reg, 32'b0} + {31'b0, pp_lo_reg};
    assign sat_next    = |full[96:95];
    assign result_next = sat_next ? abt_pkg::SAT_MAX : full[94:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            stage1_reg <= start;
            done_reg   <= stage1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
        end
        if (stage1_reg)
        begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign sat    = sat_reg;

endmodule

// ----- sv/abt_ctrl.sv -----
// ============================================================================
// abt_ctrl
// Lattice sequencer: node price and option value memories, leaf setup and
// level-by-level rollback through one shared multiplier.
// ============================================================================
module abt_ctrl
#(
    parameter int MAX_STEPS = 1024
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  abt_pkg::cfg_t             cfg,
    input  logic                      start,
    input  abt_pkg::price_t           spot,
    input  logic [abt_pkg::NIN_W-1:0] steps,
    input  logic                      take,
    output abt_pkg::status_t          status
);

    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int NW = (CW > abt_pkg::NIN_W) ? CW : abt_pkg::NIN_W;

    typedef enum logic [17:0] {
        ST_IDLE      = 18'h00001,
        ST_NODE_MUL  = 18'h00002,
        ST_NODE_WAIT = 18'h00004,
        ST_LEAF_RD   = 18'h00008,
        ST_LEAF_LD   = 18'h00010,
        ST_LEAF_PAY  = 18'h00020,
        ST_LEAF_U1   = 18'h00040,
        ST_LEAF_U2   = 18'h00080,
        ST_LVL_RD    = 18'h00100,
        ST_LVL_LD    = 18'h00200,
        ST_HI_RD     = 18'h00400,
        ST_HI_LD     = 18'h00800,
        ST_W_UP      = 18'h01000,
        ST_W_DN      = 18'h02000,
        ST_P_U1      = 18'h04000,
        ST_P_U2      = 18'h08000,
        ST_RES_RD    = 18'h10000,
        ST_RES_LD    = 18'h20000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic            sat_reg, sat_next;
    abt_pkg::price_t price_reg, price_next;
    abt_pkg::price_t vlo_reg, vlo_next;
    abt_pkg::price_t vhi_reg, vhi_next;
    abt_pkg::price_t prod_reg, prod_next;

    abt_pkg::price_t node_mem [MAX_STEPS];
    abt_pkg::price_t opt_mem [MAX_STEPS];
    abt_pkg::price_t node_rdata_reg;
    abt_pkg::price_t opt_rdata_reg;

    logic                node_we, node_re, opt_we, opt_re;
    logic [CW-1:0]       node_waddr, node_raddr, opt_waddr, opt_raddr;
    abt_pkg::price_t     node_wdata, opt_wdata;

    logic                    mul_start, mul_done, mul_sat;
    abt_pkg::price_t         mul_a, mul_result;
    logic [abt_pkg::UP_W-1:0] mul_b;

    logic [NW-1:0]   n_ext;
    logic [CW-1:0]   n_clamp;
    logic [CW-1:0]   k_inc, i_inc, j_dec;
    logic [63:0]     hold_sum;
    abt_pkg::price_t hold, exer, leaf_pay;

    function automatic abt_pkg::price_t payoff(abt_pkg::price_t k, abt_pkg::price_t p);
        payoff = (k > p) ? (k - p) : '0;
    endfunction

    assign n_ext   = NW'(steps);
    assign n_clamp = (n_ext == '0) ? CW'(1) :
                     ((n_ext > NW'(MAX_STEPS)) ? CW'(MAX_STEPS) : CW'(n_ext));
    assign k_inc   = k_reg + CW'(1);
    assign i_inc   = i_reg + CW'(1);
    assign j_dec   = j_reg - CW'(1);

    assign hold_sum = {1'b0, prod_reg} + {1'b0, mul_result};
    assign hold     = hold_sum[63] ? abt_pkg::SAT_MAX : hold_sum[62:0];
    assign exer     = payoff(cfg.strike_price, price_reg);
    assign leaf_pay = payoff(cfg.strike_price, price_reg);

    abt_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_result),
        .sat    (mul_sat)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        sat_next   = sat_reg | (mul_done & mul_sat);
        price_next = price_reg;
        vlo_next   = vlo_reg;
        vhi_next   = vhi_reg;
        prod_next  = prod_reg;
        node_we    = 1'b0;
        node_re    = 1'b0;
        opt_we     = 1'b0;
        opt_re     = 1'b0;
        node_waddr = k_reg;
        node_raddr = j_dec;
        opt_waddr  = i_reg;
        opt_raddr  = i_inc;
        node_wdata = mul_result;
        opt_wdata  = leaf_pay;
        mul_start  = 1'b0;
        mul_a      = price_reg;
        mul_b      = cfg.up_factor;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = n_clamp;
                    k_next     = '0;
                    price_next = spot;
                    sat_next   = 1'b0;
                    state_next = ST_NODE_MUL;
                end
            end
            ST_NODE_MUL:
            begin
                mul_start  = 1'b1;
                mul_b      = {1'b0, cfg.down_factor};
                state_next = ST_NODE_WAIT;
            end
            ST_NODE_WAIT:
            begin
                if (mul_done)
                begin
                    node_we    = 1'b1;
                    price_next = mul_result;
                    k_next     = k_inc;
                    state_next = (k_inc == n_reg) ? ST_LEAF_RD : ST_NODE_MUL;
                end
            end
            ST_LEAF_RD:
            begin
                node_re    = 1'b1;
                node_raddr = n_reg - CW'(1);
                state_next = ST_LEAF_LD;
            end
            ST_LEAF_LD:
            begin
                price_next = node_rdata_reg;
                i_next     = '0;
                state_next = ST_LEAF_PAY;
            end
            ST_LEAF_PAY:
            begin
                opt_we     = 1'b1;
                mul_start  = 1'b1;
                state_next = ST_LEAF_U1;
            end
            ST_LEAF_U1:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_result;
                    state_next = ST_LEAF_U2;
                end
            end
            ST_LEAF_U2:
            begin
                if (mul_done)
                begin
                    price_next = mul_result;
                    i_next     = i_inc;
                    if (i_inc == n_reg)
                    begin
                        j_next     = n_reg - CW'(1);
                        state_next = (n_reg == CW'(1)) ? ST_RES_RD : ST_LVL_RD;
                    end
                    else
                    begin
                        state_next = ST_LEAF_PAY;
                    end
                end
            end
            ST_LVL_RD:
            begin
                node_re    = 1'b1;
                opt_re     = 1'b1;
                opt_raddr  = '0;
                state_next = ST_LVL_LD;
            end
            ST_LVL_LD:
            begin
                price_next = node_rdata_reg;
                vlo_next   = opt_rdata_reg;
                i_next     = '0;
                state_next = ST_HI_RD;
            end
            ST_HI_RD:
            begin
                opt_re     = 1'b1;
                state_next = ST_HI_LD;
            end
            ST_HI_LD:
            begin
                vhi_next   = opt_rdata_reg;
                mul_start  = 1'b1;
                mul_a      = opt_rdata_reg;
                mul_b      = {1'b0, cfg.weight_up};
                state_next = ST_W_UP;
            end
            ST_W_UP:
            begin
                if (mul_done)
                begin
                    prod_next  = mul_result;
                    mul_start  = 1'b1;
                    mul_a      = vlo_reg;
                    mul_b      = {1'b0, cfg.weight_down};
                    state_next = ST_W_DN;
                end
            end
            ST_W_DN:
            begin
                if (mul_done)
                begin
                    sat_next   = sat_reg | mul_sat | hold_sum[63];
                    opt_we     = 1'b1;
                    opt_wdata  = (hold > exer) ? hold : exer;
                    vlo_next   = vhi_reg;
                    mul_start  = 1'b1;
                    state_next = ST_P_U1;
                end
            end
            ST_P_U1:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_result;
                    state_next = ST_P_U2;
                end
            end
            ST_P_U2:
            begin
                if (mul_done)
                begin
                    price_next = mul_result;
                    if (i_inc == j_reg)
                    begin
                        j_next     = j_dec;
                        state_next = (j_reg == CW'(1)) ? ST_RES_RD : ST_LVL_RD;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = ST_HI_RD;
                    end
                end
            end
            ST_RES_RD:
            begin
                opt_re     = 1'b1;
                opt_raddr  = '0;
                state_next = ST_RES_LD;
            end
            ST_RES_LD:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        vlo_reg   <= vlo_next;
        vhi_reg   <= vhi_next;
        prod_reg  <= prod_next;
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr[AW-1:0]] <= node_wdata;
        end
        if (node_re)
        begin
            node_rdata_reg <= node_mem[node_raddr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (opt_we)
        begin
            opt_mem[opt_waddr[AW-1:0]] <= opt_wdata;
        end
        if (opt_re)
        begin
            opt_rdata_reg <= opt_mem[opt_raddr[AW-1:0]];
        end
    end

    assign status.idle  = (state_reg == ST_IDLE);
    assign status.done  = (state_reg == ST_RES_LD);
    assign status.price = opt_rdata_reg;
    assign status.sat   = sat_reg;

`ifndef SYNTHESIS
    a_mul_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |=> !mul_start)
        else $error("multiplier restarted before its result was back");

    a_opt_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        opt_we |-> (i_reg < n_reg))
        else $error("option value written beyond the active lattice");

    a_roll_indexes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HI_RD) |-> ((i_reg < j_reg) && (j_reg < n_reg)))
        else $error("rollback node index out of its level");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (state_reg == ST_IDLE)) |=> (state_reg == ST_NODE_MUL))
        else $error("accepted request did not begin the node price pass");
`endif

endmodule

// ----- sv/american_put_binomial_tree.sv -----
// ============================================================================
// american_put_binomial_tree
// Prices an American put on a recombining binomial lattice in Q31.32.
//
//  Channel   Direction  Signals                    Beat contents
//  s_axis    in         tvalid tready tdata[79:0]  spot_price, step_count
//  m_axis    out        tvalid tready tdata[63:0]  option_price; tuser saturated
//  cfg       in         valid ready index data     register write
//
//  A rollback node needs four products from the single multiplier, a leaf two.
//  Reset clears the sequencer and output flag and loads the config defaults;
//  the memories and the data registers are not cleared.
//  A new request is taken only while the sequencer is idle.
//  A finished result waits in the output register while the next request runs.
// ============================================================================
module american_put_binomial_tree
#(
    parameter int MAX_STEPS = 1024
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0: spot_price[62:0], step_count[73:63], zero fill.
    input  logic [79:0]                 s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // Fields from bit 0: option_price[62:0], zero fill.
    output logic [63:0]                 m_axis_tdata,
    // Fields from bit 0: saturated.
    output logic                        m_axis_tuser,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [abt_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [abt_pkg::CDATA_W-1:0] cfg_data
);

    abt_pkg::cfg_t    cfg_reg;
    abt_pkg::status_t status;
    logic             start;
    logic             take;
    logic             out_valid_reg;
    abt_pkg::price_t  out_price_reg;
    logic             out_sat_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_factor    <= 34'h100000000;
            cfg_reg.down_factor  <= 33'h100000000;
            cfg_reg.weight_up    <= '0;
            cfg_reg.weight_down  <= '0;
            cfg_reg.strike_price <= '0;
        end
        else if (cfg_valid)
        begin
            case (abt_pkg::cfg_reg_t'(cfg_index))
                abt_pkg::REG_UP:     cfg_reg.up_factor    <= cfg_data[33:0];
                abt_pkg::REG_DOWN:   cfg_reg.down_factor  <= cfg_data[32:0];
                abt_pkg::REG_WUP:    cfg_reg.weight_up    <= cfg_data[32:0];
                abt_pkg::REG_WDN:    cfg_reg.weight_down  <= cfg_data[32:0];
                abt_pkg::REG_STRIKE: cfg_reg.strike_price <= cfg_data[62:0];
                default:
                begin
                end
            endcase
        end
    end

    assign s_axis_tready = status.idle;
    assign start         = s_axis_tvalid & status.idle;
    assign take          = !out_valid_reg || m_axis_tready;

    abt_ctrl
    #(
        .MAX_STEPS (MAX_STEPS)
    )
    u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .start  (start),
        .spot   (s_axis_tdata[62:0]),
        .steps  (s_axis_tdata[73:63]),
        .take   (take),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= status.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && status.done)
        begin
            out_price_reg <= status.price;
            out_sat_reg   <= status.sat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_price_reg};
    assign m_axis_tuser  = out_sat_reg;

endmodule

// ----- sim/testbench.sv -----
// ============================================================================
// testbench
// Self-checking bench for the American put binomial lattice pricer. Requests
// go in on the input stream, and every price that comes back is checked
// against a fixed value or a bench-side Q31.32 lattice calculation. The bench
// runs through several register settings and idling patterns, and includes
// one long output stall.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_LEVELS = 1024;
    localparam longint      RUN_LIMIT  = 40_000_000;
    localparam logic [63:0] Q_ONE      = 64'h1_0000_0000;
    localparam logic [63:0] PRICE_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [63:0] spot;
        logic [10:0] steps;
        bit          typed;
        logic [63:0] price;
        bit          sat;
    } request_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [abt_pkg::CIDX_W-1:0]  cfg_index;
    logic [abt_pkg::CDATA_W-1:0] cfg_data;

    logic [63:0] lat_up, lat_down, lat_wup, lat_wdn, lat_strike;
    logic [63:0] lattice_value [MAX_LEVELS];
    logic [63:0] level_price [MAX_LEVELS];
    bit          sat_seen;

    logic [63:0] pending_price [$];
    bit          pending_sat [$];

    int     send_gap_pct;
    int     recv_stall_pct;
    int     hold_off_cycles;
    int     failures;
    int     requests_sent;
    int     prices_checked;
    longint cycle_count;

    american_put_binomial_tree DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:95] != 0)
        begin
            sat_seen = 1'b1;
            return PRICE_MAX;
        end
        return p[95:32];
    endfunction

    function automatic logic [63:0] q_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > {1'b0, PRICE_MAX})
        begin
            sat_seen = 1'b1;
            return PRICE_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] exercise_value(input logic [63:0] p);
        return (lat_strike > p) ? lat_strike - p : 64'd0;
    endfunction

    function automatic logic [63:0] put_price(input logic [63:0] spot, input logic [10:0] steps);
        int          n;
        logic [63:0] p;
        logic [63:0] hold;
        logic [63:0] ex;
        n = (steps == 0) ? 1 : ((steps > MAX_LEVELS) ? MAX_LEVELS : int'(steps));
        sat_seen = 1'b0;
        level_price[0] = q_mul(spot & PRICE_MAX, lat_down);
        for (int i = 1; i < n; i++)
            level_price[i] = q_mul(level_price[i-1], lat_down);
        p = level_price[n-1];
        for (int i = 0; i < n; i++)
        begin
            lattice_value[i] = exercise_value(p);
            p = q_mul(q_mul(p, lat_up), lat_up);
        end
        for (int j = n - 1; j > 0; j--)
        begin
            p = level_price[j-1];
            for (int i = 0; i < j; i++)
            begin
                hold = q_add(q_mul(lat_wup, lattice_value[i+1]), q_mul(lat_wdn, lattice_value[i]));
                ex = exercise_value(p);
                lattice_value[i] = (hold > ex) ? hold : ex;
                p = q_mul(q_mul(p, lat_up), lat_up);
            end
        end
        return lattice_value[0] & PRICE_MAX;
    endfunction

    task automatic write_reg(input abt_pkg::cfg_reg_t idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            abt_pkg::REG_UP:     lat_up     = val & 64'h3_FFFF_FFFF;
            abt_pkg::REG_DOWN:   lat_down   = val & 64'h1_FFFF_FFFF;
            abt_pkg::REG_WUP:    lat_wup    = val & 64'h1_FFFF_FFFF;
            abt_pkg::REG_WDN:    lat_wdn    = val & 64'h1_FFFF_FFFF;
            abt_pkg::REG_STRIKE: lat_strike = val & PRICE_MAX;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_lattice(input logic [63:0] u, input logic [63:0] d,
                               input logic [63:0] wu, input logic [63:0] wd,
                               input logic [63:0] k);
        wait (pending_price.size() == 0);
        repeat (40) @(posedge clk);
        write_reg(abt_pkg::REG_UP, u);
        write_reg(abt_pkg::REG_DOWN, d);
        write_reg(abt_pkg::REG_WUP, wu);
        write_reg(abt_pkg::REG_WDN, wd);
        write_reg(abt_pkg::REG_STRIKE, k);
    endtask

    // Leaves s_axis_tvalid high after the beat so back-to-back requests need no gap.
    task automatic send_request(input request_row_t r);
        logic [63:0] want;
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'd0, r.steps, r.spot[62:0]};
        do @(posedge clk); while (!s_axis_tready);
        if (r.typed)
        begin
            pending_price = {pending_price, r.price};
            pending_sat   = {pending_sat, r.sat};
        end
        else
        begin
            want = put_price(r.spot, r.steps);
            pending_price = {pending_price, want};
            pending_sat   = {pending_sat, sat_seen};
        end
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic random_phase(input int count);
        request_row_t r;
        int           pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            r.typed = 1'b0;
            if (pick < 70 && lat_strike != 0)
                r.spot = {$urandom, $urandom} % (2 * lat_strike + 1);
            else if (pick < 85)
                r.spot = {$urandom_range(32'h7FFF_FFFF), $urandom};
            else
                r.spot = {32'd0, $urandom};
            r.steps = ($urandom_range(99) < 80) ? 11'($urandom_range(16, 0)) :
                                                  11'($urandom_range(40, 17));
            send_request(r);
        end
        s_axis_tvalid = 1'b0;
    endtask

    initial
    begin
        request_row_t directed [$];
        request_row_t r;
        logic [63:0]  u;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        failures = 0;
        requests_sent = 0;
        prices_checked = 0;
        lat_up = Q_ONE;
        lat_down = Q_ONE;
        lat_wup = '0;
        lat_wdn = '0;
        lat_strike = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // With the reset registers the strike is zero, so every price is zero.
        directed = '{
            '{spot: 64'd0,     steps: 11'd1, typed: 1'b1, price: 64'd0, sat: 1'b0},
            '{spot: PRICE_MAX, steps: 11'd0, typed: 1'b1, price: 64'd0, sat: 1'b0},
            '{spot: PRICE_MAX, steps: 11'd3, typed: 1'b1, price: 64'd0, sat: 1'b0},
            '{spot: 64'd12345, steps: 11'd7, typed: 1'b1, price: 64'd0, sat: 1'b0}
        };
        foreach (directed[i])
            send_request(directed[i]);
        s_axis_tvalid = 1'b0;

        u = 64'h1_051E_B851;
        set_lattice(u, 64'((128'd1 << 64) / u), 64'd2104533975, 64'd2147483648,
                    64'd100 << 32);
        directed = '{
            '{spot: 64'd100 << 32, steps: 11'd1,    typed: 1'b0, price: 64'd0, sat: 1'b0},
            '{spot: 64'd100 << 32, steps: 11'd0,    typed: 1'b0, price: 64'd0, sat: 1'b0},
            '{spot: 64'd100 << 32, steps: 11'd2,    typed: 1'b0, price: 64'd0, sat: 1'b0},
            '{spot: 64'd90 << 32,  steps: 11'd3,    typed: 1'b0, price: 64'd0, sat: 1'b0},
            '{spot: 64'd0,         steps: 11'd5,    typed: 1'b0, price: 64'd0, sat: 1'b0},
            '{spot: PRICE_MAX,     steps: 11'd5,    typed: 1'b0, price: 64'd0, sat: 1'b0},
            '{spot: 64'd50 << 32,  steps: 11'd10,   typed: 1'b0, price: 64'd0, sat: 1'b0},
            '{spot: 64'd200 << 32, steps: 11'd10,   typed: 1'b0, price: 64'd0, sat: 1'b0},
            '{spot: 64'd100 << 32, steps: 11'd2047, typed: 1'b0, price: 64'd0, sat: 1'b0}
        };
        foreach (directed[i])
            send_request(directed[i]);
        s_axis_tvalid = 1'b0;

        // The output is held off for a long stretch while requests keep coming.
        hold_off_cycles = 3000;
        random_phase(25);

        set_lattice(64'h2_0000_0000, 64'd0, Q_ONE, Q_ONE, PRICE_MAX);
        send_gap_pct = 57;
        random_phase(25);

        set_lattice(Q_ONE, Q_ONE, 64'd0, 64'd0, 64'd0);
        send_gap_pct = 0;
        recv_stall_pct = 57;
        random_phase(10);

        u = Q_ONE + 64'($urandom_range(32'h4000_0000));
        set_lattice(u, 64'((128'd1 << 64) / u), 64'($urandom_range(32'h8000_0000)),
                    64'($urandom_range(32'h8000_0000)), 64'($urandom_range(200, 20)) << 32);
        send_gap_pct = 21;
        recv_stall_pct = 21;
        random_phase(25);

        wait (pending_price.size() == 0);
        repeat (100) @(posedge clk);
        $display("Ran %0d pricing requests over five register settings and four idling modes,",
                 requests_sent);
        $display("including a 1024-level lattice and a long output stall; %0d prices checked.",
                 prices_checked);
        if (failures == 0)
            $display("PASS american_put_binomial_tree");
        else
            $display("FAIL american_put_binomial_tree");
        $finish;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                m_axis_tready = 1'b0;
            end
            else
                m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_price.size() == 0)
            begin
                $display("%0t: unexpected beat price=%h sat=%b", $realtime, m_axis_tdata,
                         m_axis_tuser);
                failures++;
            end
            else
            begin
                if (m_axis_tdata !== {1'b0, pending_price[0][62:0]})
                begin
                    $display("%0t: option_price expected %h actual %h", $realtime,
                             {1'b0, pending_price[0][62:0]}, m_axis_tdata);
                    failures++;
                end
                if (m_axis_tuser !== pending_sat[0])
                begin
                    $display("%0t: saturated expected %b actual %b", $realtime,
                             pending_sat[0], m_axis_tuser);
                    failures++;
                end
                void'(pending_price.pop_front());
                void'(pending_sat.pop_front());
                prices_checked++;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > RUN_LIMIT)
            begin
                $display("FAIL american_put_binomial_tree");
                $finish;
            end
        end
    end

endmodule
